// ===== rtl/eapfp_pkg.sv =====
// Package for the EAPOL/EAP frame parser: constants, result word type, helper functions.
`default_nettype none

package eapfp_pkg;

    // Default for the saturation point of the byte counter
    localparam int MAX_FRAME_BYTES_DEF = 2048;

    // Byte offsets inside the Ethernet frame
    localparam int POS_ETH_HI   = 12;
    localparam int POS_ETH_LO   = 13;
    localparam int POS_VERSION  = 14;
    localparam int POS_PKT_TYPE = 15;
    localparam int POS_CODE     = 18;
    localparam int POS_ID       = 19;
    localparam int POS_LEN_HI   = 20;
    localparam int POS_LEN_LO   = 21;
    localparam int POS_TYPE     = 22;

    // Smallest frame that holds the full EAP header
    localparam int BASE_FRAME_BYTES = 22;

    // Header constants
    localparam logic [7:0] ETHERTYPE_HI    = 8'h88;
    localparam logic [7:0] ETHERTYPE_LO    = 8'h8E;
    localparam logic [7:0] PKT_TYPE_EAP    = 8'h00;
    localparam logic [7:0] EAP_CODE_REQ    = 8'd1;
    localparam logic [7:0] EAP_CODE_RSP    = 8'd2;
    localparam logic [15:0] HDR_WITH_TYPE  = 16'd5;
    localparam logic [15:0] HDR_NO_TYPE    = 16'd4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAME = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION   = 1'b1;

    // Reset values of the configuration registers
    localparam logic [10:0] MIN_FRAME_RESET = 11'd22;
    localparam logic [7:0]  VERSION_RESET   = 8'd1;

    // Result item kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // One result word
    typedef struct packed {
        logic        item_kind;
        logic [7:0]  payload_byte;
        logic        accepted;
        logic [7:0]  eap_code;
        logic [7:0]  eap_id;
        logic [15:0] eap_length;
        logic [7:0]  eap_type;
        logic        type_present;
        logic        payload_complete;
        logic        is_last;
    } out_item_t;

    // Request and Response carry a type byte
    function automatic logic code_has_type(input logic [7:0] code);
        return (code == EAP_CODE_REQ) || (code == EAP_CODE_RSP);
    endfunction

    // Payload size: EAP length minus header, floored at zero
    function automatic logic [15:0] payload_size(input logic [7:0] code,
                                                 input logic [15:0] len);
        logic [15:0] hdr;
        hdr = code_has_type(code) ? HDR_WITH_TYPE : HDR_NO_TYPE;
        return (len > hdr) ? (len - hdr) : 16'd0;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/eapfp_queue.sv =====
// Four-entry result queue that takes up to two words per cycle and gives one.
`default_nettype none

module eapfp_queue
    import eapfp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [1:0] push_cnt,
    input  wire out_item_t  item_a,
    input  wire out_item_t  item_b,
    output logic            room,
    output logic            out_valid,
    input  wire logic       out_ready,
    output out_item_t       out_item
);

    localparam int DEPTH = 4;
    localparam int PTR_W = 2;

    out_item_t            entries_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]       count_reg, count_next;
    logic                 pop;

    // Room for two words keeps the input side free of any extra check
    assign room      = (count_reg <= (PTR_W+1)'(DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_item  = entries_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + (PTR_W+1)'(push_cnt) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Word storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            entries_reg[wr_ptr_reg] <= item_a;
        end
        if (push_cnt == 2'd2)
        begin
            entries_reg[wr_ptr_reg + PTR_W'(1)] <= item_b;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/eapol_eap_frame_parser.sv =====
// Top level of the EAPOL/EAP frame parser.
//
// Frames enter one byte per word on the s_axis channel, tlast on the final
// byte. Each byte is checked against the ethertype, the EAPOL version
// register and the packet type; EAP code, id, length and type are captured.
// Payload bytes leave on m_axis as they arrive (tuser 0); at frame end one
// verdict word follows (tuser 1, tlast 1) with the accept flag and fields.
// The result words of each accepted byte are registered in the result queue.
// Throughput is one byte per cycle while s_axis_tready is high; a final byte
// that also carries payload gives two words, and the four-word result queue
// absorbs the extra one. s_axis_tready drops while the queue holds three or
// more words; header bytes give no word, so a stalled receiver holds the
// input only after at most three word-producing bytes have been taken.
// Configuration writes (cfg_we) take effect at the next clock edge; write
// only while no frame is in progress.
// Reset clears all frame state and the queue and loads the register defaults
// (minimum frame 22 bytes, EAPOL version 1).
`default_nettype none

module eapol_eap_frame_parser
    import eapfp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // Configuration write port
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // Input stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [7:0]           s_axis_tdata,   // [7:0] rx_byte
    input  wire logic                 s_axis_tlast,   // frame_end
    // Result stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [55:0]               m_axis_tdata,   // payload_byte, accepted, eap_code,
                                                      // eap_id, eap_length, eap_type,
                                                      // type_present, payload_complete, 0 pad
    output logic                      m_axis_tuser,   // item_kind
    output logic                      m_axis_tlast    // is_last
);

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BYTES);

    // Configuration registers
    logic [10:0]      min_frame_reg;
    logic [7:0]       version_reg;

    // Frame state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             reject_reg, reject_next;
    logic [7:0]       eth_hi_reg, eth_hi_next;
    logic [7:0]       code_reg, code_next;
    logic [7:0]       id_reg, id_next;
    logic [15:0]      length_reg, length_next;
    logic [7:0]       type_reg, type_next;
    logic [POS_W-1:0] pcount_reg, pcount_next;

    logic             in_fire;
    logic [7:0]       rx_byte;
    logic             frame_end;
    logic             emit_payload;
    logic             has_type_old;
    logic             has_type_new;
    logic [15:0]      psize_old;
    logic [15:0]      psize_new;
    logic [POS_W-1:0] offset;
    logic             frame_ok;
    logic [1:0]       push_cnt;
    logic             q_room;
    out_item_t        pay_item;
    out_item_t        verdict_item;
    out_item_t        item_a;
    out_item_t        out_item;

    assign rx_byte   = s_axis_tdata;
    assign frame_end = s_axis_tlast;
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = q_room;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_frame_reg <= MIN_FRAME_RESET;
            version_reg   <= VERSION_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIN_FRAME: min_frame_reg <= cfg_data;
                CFG_VERSION:   version_reg   <= cfg_data[7:0];
                default:       ;
            endcase
        end
    end

    // Per-byte header decode, capture and payload selection
    always_comb
    begin
        has_type_old = code_has_type(code_reg);
        psize_old    = payload_size(code_reg, length_reg);
        offset       = has_type_old ? POS_W'(POS_TYPE + 1) : POS_W'(POS_TYPE);

        pos_next     = pos_reg;
        reject_next  = reject_reg;
        eth_hi_next  = eth_hi_reg;
        code_next    = code_reg;
        id_next      = id_reg;
        length_next  = length_reg;
        type_next    = type_reg;
        pcount_next  = pcount_reg;
        emit_payload = 1'b0;

        if (pos_reg >= POS_MAX)
        begin
            // Oversize: count holds, frame is rejected
            reject_next = 1'b1;
        end
        else
        begin
            if (pos_reg == POS_W'(POS_ETH_HI))
            begin
                eth_hi_next = rx_byte;
            end
            else if (pos_reg == POS_W'(POS_ETH_LO))
            begin
                if (eth_hi_reg != ETHERTYPE_HI || rx_byte != ETHERTYPE_LO)
                begin
                    reject_next = 1'b1;
                end
            end
            else if (pos_reg == POS_W'(POS_VERSION))
            begin
                if (rx_byte != version_reg)
                begin
                    reject_next = 1'b1;
                end
            end
            else if (pos_reg == POS_W'(POS_PKT_TYPE))
            begin
                if (rx_byte != PKT_TYPE_EAP)
                begin
                    reject_next = 1'b1;
                end
            end
            else if (pos_reg == POS_W'(POS_CODE))
            begin
                code_next = rx_byte;
            end
            else if (pos_reg == POS_W'(POS_ID))
            begin
                id_next = rx_byte;
            end
            else if (pos_reg == POS_W'(POS_LEN_HI))
            begin
                length_next = {rx_byte, 8'h00};
            end
            else if (pos_reg == POS_W'(POS_LEN_LO))
            begin
                length_next = {length_reg[15:8], length_reg[7:0] | rx_byte};
            end
            else if (pos_reg == POS_W'(POS_TYPE) && has_type_old)
            begin
                type_next = rx_byte;
            end

            // Forward payload while the header is good and bytes remain
            if (pos_reg >= offset && !reject_next && (16'(pcount_reg) < psize_old))
            begin
                emit_payload = 1'b1;
                pcount_next  = pcount_reg + POS_W'(1);
            end
            pos_next = pos_reg + POS_W'(1);
        end

        // Verdict uses the state as updated by this byte
        has_type_new = code_has_type(code_next);
        psize_new    = payload_size(code_next, length_next);
        frame_ok     = !reject_next
                       && (16'(pos_next) >= 16'(min_frame_reg))
                       && (16'(pos_next) >= 16'(BASE_FRAME_BYTES))
                       && (!has_type_new || (16'(pos_next) >= 16'(BASE_FRAME_BYTES + 1)));
    end

    // Result words
    always_comb
    begin
        pay_item              = '0;
        pay_item.item_kind    = KIND_PAYLOAD;
        pay_item.payload_byte = rx_byte;

        verdict_item           = '0;
        verdict_item.item_kind = KIND_VERDICT;
        verdict_item.is_last   = 1'b1;
        if (frame_ok)
        begin
            verdict_item.accepted         = 1'b1;
            verdict_item.eap_code         = code_next;
            verdict_item.eap_id           = id_next;
            verdict_item.eap_length       = length_next;
            verdict_item.eap_type         = has_type_new ? type_next : 8'd0;
            verdict_item.type_present     = has_type_new;
            verdict_item.payload_complete = (psize_new != 16'd0)
                                            && (16'(pcount_next) == psize_new);
        end

        item_a   = emit_payload ? pay_item : verdict_item;
        push_cnt = in_fire ? (2'(emit_payload) + 2'(frame_end)) : 2'd0;
    end

    // Frame state registers; cleared after the final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            reject_reg <= 1'b0;
            eth_hi_reg <= '0;
            code_reg   <= '0;
            id_reg     <= '0;
            length_reg <= '0;
            type_reg   <= '0;
            pcount_reg <= '0;
        end
        else if (in_fire)
        begin
            if (frame_end)
            begin
                pos_reg    <= '0;
                reject_reg <= 1'b0;
                eth_hi_reg <= '0;
                code_reg   <= '0;
                id_reg     <= '0;
                length_reg <= '0;
                type_reg   <= '0;
                pcount_reg <= '0;
            end
            else
            begin
                pos_reg    <= pos_next;
                reject_reg <= reject_next;
                eth_hi_reg <= eth_hi_next;
                code_reg   <= code_next;
                id_reg     <= id_next;
                length_reg <= length_next;
                type_reg   <= type_next;
                pcount_reg <= pcount_next;
            end
        end
    end

    // Result queue between the parser and the output channel
    eapfp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .item_a    (item_a),
        .item_b    (verdict_item),
        .room      (q_room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_item  (out_item)
    );

    // Output packing
    assign m_axis_tdata = {5'd0,
                           out_item.payload_complete,
                           out_item.type_present,
                           out_item.eap_type,
                           out_item.eap_length,
                           out_item.eap_id,
                           out_item.eap_code,
                           out_item.accepted,
                           out_item.payload_byte};
    assign m_axis_tuser = out_item.item_kind;
    assign m_axis_tlast = out_item.is_last;

endmodule

`default_nettype wire
